@@ design/kvd_pkg.sv @@
// ----------------------------------------------------------------------------
// kvd_pkg: shared types, constants and helpers for the vertex decompressor
// Q16.16 value type, saturating clamp and negate, opcode, register index
// and orientation flag codes.
// ----------------------------------------------------------------------------
package kvd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;
    localparam int Q_W       = 32;
    localparam int BYTE_W    = 8;
    localparam int SUM_W     = BYTE_W + Q_W;
    localparam int PROD_W    = 2 * Q_W;
    localparam int ORIENT_W  = 6;

    typedef logic signed [Q_W-1:0] t_q;
    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [ORIENT_W-1:0]   t_orient;

    localparam t_q Q_MAX         = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN         = 32'sh8000_0000;
    localparam t_q USCALE_RESET  = 32'sd65536;

    localparam logic signed [PROD_W-1:0] WIDE_MAX = PROD_W'(Q_MAX);
    localparam logic signed [PROD_W-1:0] WIDE_MIN = PROD_W'(Q_MIN);

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    typedef enum logic [1:0] {
        CFG_USCALE_X,
        CFG_USCALE_Y,
        CFG_USCALE_Z,
        CFG_ORIENT
    } t_cfg_idx;

    localparam int ORI_NEG_X   = 0;
    localparam int ORI_NEG_Y   = 1;
    localparam int ORI_NEG_Z   = 2;
    localparam int ORI_SWAP_YZ = 3;
    localparam int ORI_SWAP_XZ = 4;
    localparam int ORI_SWAP_XY = 5;

    typedef struct packed {
        t_q   val;
        logic sat;
    } t_sat_q;

    function automatic t_sat_q clamp_q(input logic signed [PROD_W-1:0] v);
        t_sat_q r;
        if (v > WIDE_MAX) begin
            r.val = Q_MAX;
            r.sat = 1'b1;
        end else if (v < WIDE_MIN) begin
            r.val = Q_MIN;
            r.sat = 1'b1;
        end else begin
            r.val = v[Q_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // Only the most negative value cannot be negated in range.
    function automatic t_sat_q neg_q(input t_q v);
        t_sat_q r;
        if (v == Q_MIN) begin
            r.val = Q_MAX;
            r.sat = 1'b1;
        end else begin
            r.val = -v;
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ design/keyframe_vertex_decompress.sv @@
// ----------------------------------------------------------------------------
// keyframe_vertex_decompress: packed keyframe vertex decoder, Q16.16
// Top level: input and output beats, configuration registers, and the
// decode, scale and orientation pipeline.
// ----------------------------------------------------------------------------
// A header beat (opcode 0) loads the frame scale and offset and gives no
// output; a vertex beat (opcode 1) gives one position. The datapath is a
// five-stage pipeline (byte multiply-add, clamp, 32x32 user-scale multiply,
// shift and clamp, orientation and output register), so one beat is taken
// every clock while the input is not stalled, and a header takes effect for
// the very next vertex. A stall on the output holds the pipeline stages that
// are full; empty stages keep filling, so bubbles are squeezed out. The
// configuration registers are read by the later stages and must only be
// written while no vertex is in flight.
module keyframe_vertex_decompress import kvd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input beats
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  t_q         i_hdr_scale_x,
    input  t_q         i_hdr_scale_y,
    input  t_q         i_hdr_scale_z,
    input  t_q         i_hdr_offset_x,
    input  t_q         i_hdr_offset_y,
    input  t_q         i_hdr_offset_z,
    input  t_byte      i_packed_x,
    input  t_byte      i_packed_y,
    input  t_byte      i_packed_z,
    // output beats
    output logic       o_valid,
    input  logic       i_stall,
    output t_q         o_pos_x,
    output t_q         o_pos_y,
    output t_q         o_pos_z,
    output logic       o_saturated,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [Q_W-1:0] i_cfg_data
);

    t_q      r_user_scale [NUM_AXES];
    t_orient r_orient;

    t_q    w_hdr_scale  [NUM_AXES];
    t_q    w_hdr_offset [NUM_AXES];
    t_byte w_packed     [NUM_AXES];
    t_q    w_dec_val    [NUM_AXES];
    t_q    w_sc_val     [NUM_AXES];
    t_q    w_out_val    [NUM_AXES];
    logic  w_accept;
    logic  w_hdr_load;
    logic  w_in_vertex;
    logic  w_dec_ready;
    logic  w_dec_v;
    logic  w_dec_sat;
    logic  w_sc_ready;
    logic  w_sc_v;
    logic  w_sc_sat;
    logic  w_ori_ready;

    assign w_hdr_scale  = '{i_hdr_scale_x, i_hdr_scale_y, i_hdr_scale_z};
    assign w_hdr_offset = '{i_hdr_offset_x, i_hdr_offset_y, i_hdr_offset_z};
    assign w_packed     = '{i_packed_x, i_packed_y, i_packed_z};

    assign o_stall     = !w_dec_ready;
    assign w_accept    = i_valid && w_dec_ready;
    assign w_hdr_load  = w_accept && (i_opcode == OP_HEADER);
    // Header beats never enter the pipeline.
    assign w_in_vertex = i_valid && (i_opcode == OP_VERTEX);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_user_scale[i] <= USCALE_RESET;
            end
            r_orient <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_USCALE_X: r_user_scale[0] <= i_cfg_data;
                CFG_USCALE_Y: r_user_scale[1] <= i_cfg_data;
                CFG_USCALE_Z: r_user_scale[2] <= i_cfg_data;
                CFG_ORIENT:   r_orient        <= i_cfg_data[ORIENT_W-1:0];
                default:      r_orient        <= r_orient;
            endcase
        end
    end

    kvd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hdr_load   (w_hdr_load),
        .i_hdr_scale  (w_hdr_scale),
        .i_hdr_offset (w_hdr_offset),
        .i_valid      (w_in_vertex),
        .o_ready      (w_dec_ready),
        .i_packed     (w_packed),
        .o_valid      (w_dec_v),
        .i_ready      (w_sc_ready),
        .o_val        (w_dec_val),
        .o_sat        (w_dec_sat)
    );

    kvd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_user_scale (r_user_scale),
        .i_valid      (w_dec_v),
        .o_ready      (w_sc_ready),
        .i_val        (w_dec_val),
        .i_sat        (w_dec_sat),
        .o_valid      (w_sc_v),
        .i_ready      (w_ori_ready),
        .o_val        (w_sc_val),
        .o_sat        (w_sc_sat)
    );

    kvd_orient u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (r_orient),
        .i_valid (w_sc_v),
        .o_ready (w_ori_ready),
        .i_val   (w_sc_val),
        .i_sat   (w_sc_sat),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_val   (w_out_val),
        .o_sat   (o_saturated)
    );

    assign o_pos_x = w_out_val[0];
    assign o_pos_y = w_out_val[1];
    assign o_pos_z = w_out_val[2];

    // Back-pressure reaches the input only when every stage is full.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && w_sc_v && w_dec_v))
        else $error("input stalled while the pipeline has room");

    // A new output beat always comes from the scale stage.
    a_out_from_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_sc_v))
        else $error("output valid without a beat in the scale stage");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !w_sc_v && !w_dec_v))
        else $error("pipeline not empty after reset");

endmodule

@@ design/kvd_decode.sv @@
// ----------------------------------------------------------------------------
// kvd_decode: frame decode stages
// Holds the frame scale and offset, forms byte * scale + offset per axis and
// clamps the sum to 32 bits. Two register stages.
// ----------------------------------------------------------------------------
module kvd_decode import kvd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_hdr_load,
    input  t_q    i_hdr_scale  [NUM_AXES],
    input  t_q    i_hdr_offset [NUM_AXES],
    input  logic  i_valid,
    output logic  o_ready,
    input  t_byte i_packed [NUM_AXES],
    output logic  o_valid,
    input  logic  i_ready,
    output t_q    o_val [NUM_AXES],
    output logic  o_sat
);

    t_q                       r_frame_scale  [NUM_AXES];
    t_q                       r_frame_offset [NUM_AXES];
    logic signed [SUM_W-1:0]  r_sum [NUM_AXES];
    logic signed [SUM_W-1:0]  n_sum [NUM_AXES];
    t_q                       r_val [NUM_AXES];
    t_sat_q                   w_cl  [NUM_AXES];
    logic [NUM_AXES-1:0]      w_cl_sat;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_sat;
    logic                     w_en1;
    logic                     w_en2;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n_sum[i] = SUM_W'($signed({1'b0, i_packed[i]})) * SUM_W'(r_frame_scale[i])
                     + SUM_W'(r_frame_offset[i]);
            w_cl[i]     = clamp_q(PROD_W'(r_sum[i]));
            w_cl_sat[i] = w_cl[i].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_frame_scale[i]  <= '0;
                r_frame_offset[i] <= '0;
            end
        end else begin
            if (i_hdr_load) begin
                r_frame_scale  <= i_hdr_scale;
                r_frame_offset <= i_hdr_offset;
            end
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_sum <= n_sum;
        end
        if (w_en2) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_val[i] <= w_cl[i].val;
            end
            r_sat <= |w_cl_sat;
        end
    end

    assign o_valid = r_v2;
    assign o_val   = r_val;
    assign o_sat   = r_sat;

endmodule

@@ design/kvd_scale.sv @@
// ----------------------------------------------------------------------------
// kvd_scale: user scale stages
// Multiplies each decoded axis by its user scale, then drops the fraction
// bits (floor) and clamps to 32 bits. Two register stages.
// ----------------------------------------------------------------------------
module kvd_scale import kvd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_q   i_user_scale [NUM_AXES],
    input  logic i_valid,
    output logic o_ready,
    input  t_q   i_val [NUM_AXES],
    input  logic i_sat,
    output logic o_valid,
    input  logic i_ready,
    output t_q   o_val [NUM_AXES],
    output logic o_sat
);

    logic signed [PROD_W-1:0] r_prod [NUM_AXES];
    logic signed [PROD_W-1:0] n_prod [NUM_AXES];
    t_q                       r_val  [NUM_AXES];
    t_sat_q                   w_cl   [NUM_AXES];
    logic [NUM_AXES-1:0]      w_cl_sat;
    logic                     r_v3;
    logic                     r_v4;
    logic                     r_sat3;
    logic                     r_sat4;
    logic                     w_en3;
    logic                     w_en4;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n_prod[i]   = PROD_W'(i_val[i]) * PROD_W'(i_user_scale[i]);
            // Arithmetic shift of the exact product rounds toward minus infinity.
            w_cl[i]     = clamp_q(r_prod[i] >>> FRAC_BITS);
            w_cl_sat[i] = w_cl[i].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_prod <= n_prod;
            r_sat3 <= i_sat;
        end
        if (w_en4) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_val[i] <= w_cl[i].val;
            end
            r_sat4 <= r_sat3 | (|w_cl_sat);
        end
    end

    assign o_valid = r_v4;
    assign o_val   = r_val;
    assign o_sat   = r_sat4;

endmodule

@@ design/kvd_orient.sv @@
// ----------------------------------------------------------------------------
// kvd_orient: orientation and output register
// Applies the negate flags, then the y/z, x/z and x/y swaps in that order,
// and holds the finished position for the output beat.
// ----------------------------------------------------------------------------
module kvd_orient import kvd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_orient i_flags,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_q      i_val [NUM_AXES],
    input  logic    i_sat,
    output logic    o_valid,
    input  logic    i_ready,
    output t_q      o_val [NUM_AXES],
    output logic    o_sat
);

    t_q                  r_val [NUM_AXES];
    t_q                  n_val [NUM_AXES];
    t_sat_q              w_neg [NUM_AXES];
    logic [NUM_AXES-1:0] w_neg_sat;
    t_q                  w_tmp;
    logic                r_v5;
    logic                r_sat;
    logic                w_en5;

    assign w_en5   = !r_v5 || i_ready;
    assign o_ready = w_en5;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            w_neg[i] = neg_q(i_val[i]);
            if (i_flags[ORI_NEG_X + i]) begin
                n_val[i]     = w_neg[i].val;
                w_neg_sat[i] = w_neg[i].sat;
            end else begin
                n_val[i]     = i_val[i];
                w_neg_sat[i] = 1'b0;
            end
        end
        w_tmp = n_val[1];
        if (i_flags[ORI_SWAP_YZ]) begin
            w_tmp    = n_val[1];
            n_val[1] = n_val[2];
            n_val[2] = w_tmp;
        end
        if (i_flags[ORI_SWAP_XZ]) begin
            w_tmp    = n_val[0];
            n_val[0] = n_val[2];
            n_val[2] = w_tmp;
        end
        if (i_flags[ORI_SWAP_XY]) begin
            w_tmp    = n_val[0];
            n_val[0] = n_val[1];
            n_val[1] = w_tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en5) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_val <= n_val;
            r_sat <= i_sat | (|w_neg_sat);
        end
    end

    assign o_valid = r_v5;
    assign o_val   = r_val;
    assign o_sat   = r_sat;

endmodule
